// File: sv/bitonic_sorter_any_length_unit_macros.svh
`ifndef BITONIC_SORTER_ANY_LENGTH_UNIT_MACROS_SVH
`define BITONIC_SORTER_ANY_LENGTH_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BSAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BSAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bsal_pkg.sv
`default_nettype none

package bsal_pkg;

    localparam int VAL_W = 32;
    localparam int UPC_W = 4;

    typedef logic signed [VAL_W-1:0] t_val;

    // extreme values used as padding sentinels
    localparam t_val VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // memory operations
    localparam logic [2:0] MEM_NONE    = 3'd0;
    localparam logic [2:0] MEM_PAD     = 3'd1;
    localparam logic [2:0] MEM_RD_PAIR = 3'd2;
    localparam logic [2:0] MEM_WR_LO   = 3'd3;
    localparam logic [2:0] MEM_WR_HI   = 3'd4;
    localparam logic [2:0] MEM_RD_EMIT = 3'd5;

    // index pointer operations
    localparam logic [1:0] IDX_HOLD     = 2'd0;
    localparam logic [1:0] IDX_INC      = 2'd1;
    localparam logic [1:0] IDX_CLR      = 2'd2;
    localparam logic [1:0] IDX_LOAD_CNT = 2'd3;

    // network stage operations
    localparam logic [1:0] STG_HOLD = 2'd0;
    localparam logic [1:0] STG_INIT = 2'd1;
    localparam logic [1:0] STG_NEXT = 2'd2;

    // jump conditions
    localparam logic [3:0] C_ALWAYS     = 4'd0;
    localparam logic [3:0] C_NO_FINAL   = 4'd1;
    localparam logic [3:0] C_IDX_AT_TOP = 4'd2;
    localparam logic [3:0] C_SKIP       = 4'd3;
    localparam logic [3:0] C_I_MORE     = 4'd4;
    localparam logic [3:0] C_STG_MORE   = 4'd5;
    localparam logic [3:0] C_OUT_BUSY   = 4'd6;
    localparam logic [3:0] C_EMIT_MORE  = 4'd7;

    // program steps
    localparam logic [UPC_W-1:0] S_LOAD     = 4'd0;
    localparam logic [UPC_W-1:0] S_SETUP    = 4'd1;
    localparam logic [UPC_W-1:0] S_PAD_CHK  = 4'd2;
    localparam logic [UPC_W-1:0] S_PAD_WR   = 4'd3;
    localparam logic [UPC_W-1:0] S_STAGE    = 4'd4;
    localparam logic [UPC_W-1:0] S_CE_RD    = 4'd5;
    localparam logic [UPC_W-1:0] S_CE_WLO   = 4'd6;
    localparam logic [UPC_W-1:0] S_CE_WHI   = 4'd7;
    localparam logic [UPC_W-1:0] S_CE_NEXT  = 4'd8;
    localparam logic [UPC_W-1:0] S_STG_NEXT = 4'd9;
    localparam logic [UPC_W-1:0] S_EM_INIT  = 4'd10;
    localparam logic [UPC_W-1:0] S_EM_RD    = 4'd11;
    localparam logic [UPC_W-1:0] S_EM_WAIT  = 4'd12;
    localparam logic [UPC_W-1:0] S_EM_PUSH  = 4'd13;
    localparam logic [UPC_W-1:0] S_DONE     = 4'd14;

    typedef struct packed {
        logic       in_rdy;
        logic [2:0] mem_op;
        logic [1:0] idx_op;
        logic [1:0] stg_op;
        logic       out_ld;
        logic       clr_batch;
    } t_ctl;

    typedef struct packed {
        t_ctl             ctl;
        logic [3:0]       cond;
        logic [UPC_W-1:0] tgt;
    } t_cw;

    typedef struct packed {
        logic final_acc;
        logic idx_at_top;
        logic skip;
        logic i_last;
        logic stg_last;
        logic out_free;
        logic emit_last;
    } t_status;

    // control store: jump to tgt when cond holds, else fall through
    function automatic t_cw ucode(input logic [UPC_W-1:0] pc);
        t_cw cw;
        cw = '0;
        unique case (pc)
            S_LOAD: begin
                cw.ctl.in_rdy = 1'b1;
                cw.cond       = C_NO_FINAL;
                cw.tgt        = S_LOAD;
            end
            S_SETUP: begin
                cw.ctl.idx_op = IDX_LOAD_CNT;
                cw.ctl.stg_op = STG_INIT;
                cw.cond       = C_ALWAYS;
                cw.tgt        = S_PAD_CHK;
            end
            S_PAD_CHK: begin
                cw.cond = C_IDX_AT_TOP;
                cw.tgt  = S_STAGE;
            end
            S_PAD_WR: begin
                cw.ctl.mem_op = MEM_PAD;
                cw.ctl.idx_op = IDX_INC;
                cw.cond       = C_ALWAYS;
                cw.tgt        = S_PAD_CHK;
            end
            S_STAGE: begin
                cw.ctl.idx_op = IDX_CLR;
                cw.cond       = C_ALWAYS;
                cw.tgt        = S_CE_RD;
            end
            S_CE_RD: begin
                cw.ctl.mem_op = MEM_RD_PAIR;
                cw.cond       = C_SKIP;
                cw.tgt        = S_CE_NEXT;
            end
            S_CE_WLO: begin
                cw.ctl.mem_op = MEM_WR_LO;
                cw.cond       = C_ALWAYS;
                cw.tgt        = S_CE_WHI;
            end
            S_CE_WHI: begin
                cw.ctl.mem_op = MEM_WR_HI;
                cw.cond       = C_ALWAYS;
                cw.tgt        = S_CE_NEXT;
            end
            S_CE_NEXT: begin
                cw.ctl.idx_op = IDX_INC;
                cw.cond       = C_I_MORE;
                cw.tgt        = S_CE_RD;
            end
            S_STG_NEXT: begin
                cw.ctl.stg_op = STG_NEXT;
                cw.cond       = C_STG_MORE;
                cw.tgt        = S_STAGE;
            end
            S_EM_INIT: begin
                cw.ctl.idx_op = IDX_CLR;
                cw.cond       = C_ALWAYS;
                cw.tgt        = S_EM_RD;
            end
            S_EM_RD: begin
                cw.ctl.mem_op = MEM_RD_EMIT;
                cw.cond       = C_ALWAYS;
                cw.tgt        = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                cw.cond = C_OUT_BUSY;
                cw.tgt  = S_EM_WAIT;
            end
            S_EM_PUSH: begin
                cw.ctl.out_ld = 1'b1;
                cw.ctl.idx_op = IDX_INC;
                cw.cond       = C_EMIT_MORE;
                cw.tgt        = S_EM_RD;
            end
            S_DONE: begin
                cw.ctl.clr_batch = 1'b1;
                cw.cond          = C_ALWAYS;
                cw.tgt           = S_LOAD;
            end
            default: begin
                cw.cond = C_ALWAYS;
                cw.tgt  = S_LOAD;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// File: sv/bsal_if.sv
`default_nettype none

interface bsal_in_if;
    logic           valid;
    logic           ready;
    bsal_pkg::t_val value;
    logic           final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink (input valid, input value, input final_item, output ready);
endinterface

interface bsal_out_if;
    logic           valid;
    logic           ready;
    bsal_pkg::t_val sorted_value;
    logic           end_of_run;
    logic           overflowed;

    modport source (output valid, output sorted_value, output end_of_run,
                    output overflowed, input ready);
    modport sink (input valid, input sorted_value, input end_of_run,
                  input overflowed, output ready);
endinterface

`default_nettype wire

// File: sv/bsal_seq.sv
`default_nettype none

`include "bitonic_sorter_any_length_unit_macros.svh"

module bsal_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsal_pkg::t_status i_status,
    output bsal_pkg::t_ctl    o_ctl
);
    import bsal_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_cw              cw;
    logic             jump;

    // fetch the control word of the current step
    assign cw    = ucode(r_upc);
    assign o_ctl = cw.ctl;

    // select the jump condition
    always_comb begin
        unique case (cw.cond)
            C_ALWAYS:     jump = 1'b1;
            C_NO_FINAL:   jump = !i_status.final_acc;
            C_IDX_AT_TOP: jump = i_status.idx_at_top;
            C_SKIP:       jump = i_status.skip;
            C_I_MORE:     jump = !i_status.i_last;
            C_STG_MORE:   jump = !i_status.stg_last;
            C_OUT_BUSY:   jump = !i_status.out_free;
            C_EMIT_MORE:  jump = !i_status.emit_last;
            default:      jump = 1'b1;
        endcase
    end

    assign n_upc = jump ? cw.tgt : r_upc + UPC_W'(1);

    // advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_LOAD;
        end else begin
            r_upc <= n_upc;
        end
    end

    `BSAL_ASSERT_NXT(a_done_to_load, i_clk, i_rst_n, r_upc == S_DONE, r_upc == S_LOAD, "batch end did not return to load")
    `BSAL_ASSERT_NXT(a_load_hold, i_clk, i_rst_n, (r_upc == S_LOAD) && !i_status.final_acc, r_upc == S_LOAD, "left load without a final beat")
    `BSAL_ASSERT_NXT(a_emit_push, i_clk, i_rst_n, (r_upc == S_EM_WAIT) && i_status.out_free, r_upc == S_EM_PUSH, "free output slot not used")

endmodule

`default_nettype wire

// File: sv/bsal_dp.sv
`default_nettype none

`include "bitonic_sorter_any_length_unit_macros.svh"

module bsal_dp #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  bsal_pkg::t_ctl    i_ctl,
    output bsal_pkg::t_status o_status,
    bsal_in_if.sink           i_in,
    bsal_out_if.source        o_out
);
    import bsal_pkg::*;

    localparam int LOG   = $clog2(MAX_ELEMENTS);
    localparam int DEPTH = 1 << LOG;
    localparam int CW    = LOG + 1;
    localparam int KW    = $clog2(LOG + 1);

    t_val mem [DEPTH];

    logic          r_asc;
    logic          r_up;
    logic [CW-1:0] r_cnt;
    logic          r_drop;
    logic [CW-1:0] r_idx;
    logic [KW-1:0] r_kl;
    logic [KW-1:0] r_jl;
    t_val          r_rda;
    t_val          r_rdb;
    logic          r_ov;
    t_val          r_oval;
    logic          r_oend;
    logic          r_oovf;

    logic           accept;
    logic           full;
    logic [LOG-1:0] addr_a;
    logic [LOG-1:0] addr_b;
    logic [LOG-1:0] j_mask;
    logic [CW-1:0]  k_mask;
    logic           blk_up;
    logic           swap;
    t_val           lo_val;
    t_val           hi_val;
    logic           we;
    logic [LOG-1:0] waddr;
    t_val           wdata;
    logic           out_free;
    logic           emit_last;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = i_ctl.in_rdy;
    assign full        = r_cnt == CW'(MAX_ELEMENTS);

    // pair addressing for the current network stage
    assign addr_a = r_idx[LOG-1:0];
    assign j_mask = LOG'(1) << r_jl;
    assign k_mask = CW'(1) << r_kl;
    assign addr_b = addr_a ^ j_mask;

    // compare-exchange: direction of this block of the network
    assign blk_up = ((r_idx & k_mask) == '0) == r_up;
    assign swap   = blk_up ? (r_rda > r_rdb) : (r_rda < r_rdb);
    assign lo_val = swap ? r_rdb : r_rda;
    assign hi_val = swap ? r_rda : r_rdb;

    assign out_free  = !r_ov || o_out.ready;
    assign emit_last = r_idx == (r_cnt - CW'(1));

    assign o_status.final_acc  = accept && i_in.final_item;
    assign o_status.idx_at_top = r_idx == CW'(DEPTH);
    assign o_status.skip       = |(addr_a & j_mask);
    assign o_status.i_last     = r_idx == CW'(DEPTH - 1);
    assign o_status.stg_last   = (r_kl == KW'(LOG)) && (r_jl == '0);
    assign o_status.out_free   = out_free;
    assign o_status.emit_last  = emit_last;

    // select the memory write
    always_comb begin
        we    = 1'b0;
        waddr = addr_a;
        wdata = i_in.value;
        priority if (accept && !full) begin
            we    = 1'b1;
            waddr = r_cnt[LOG-1:0];
        end else if (i_ctl.mem_op == MEM_PAD) begin
            we    = 1'b1;
            wdata = r_up ? VAL_MAX : VAL_MIN;
        end else if (i_ctl.mem_op == MEM_WR_LO) begin
            we    = 1'b1;
            wdata = lo_val;
        end else if (i_ctl.mem_op == MEM_WR_HI) begin
            we    = 1'b1;
            waddr = addr_b;
            wdata = hi_val;
        end
    end

    // element store with registered reads
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_ctl.mem_op == MEM_RD_PAIR || i_ctl.mem_op == MEM_RD_EMIT) begin
            r_rda <= mem[addr_a];
        end
        if (i_ctl.mem_op == MEM_RD_PAIR) begin
            r_rdb <= mem[addr_b];
        end
    end

    // direction register and batch bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asc  <= 1'b1;
            r_up   <= 1'b1;
            r_cnt  <= '0;
            r_drop <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_asc <= i_cfg_wdata;
            end
            if (accept && i_in.final_item) begin
                r_up <= r_asc;
            end
            if (i_ctl.clr_batch) begin
                r_cnt  <= '0;
                r_drop <= 1'b0;
            end else if (accept) begin
                if (full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    // index pointer and stage counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_kl  <= '0;
            r_jl  <= '0;
        end else begin
            unique case (i_ctl.idx_op)
                IDX_HOLD:     r_idx <= r_idx;
                IDX_INC:      r_idx <= r_idx + CW'(1);
                IDX_CLR:      r_idx <= '0;
                IDX_LOAD_CNT: r_idx <= r_cnt;
                default:      r_idx <= r_idx;
            endcase
            unique case (i_ctl.stg_op)
                STG_INIT: begin
                    r_kl <= KW'(1);
                    r_jl <= '0;
                end
                STG_NEXT: begin
                    if (r_jl == '0) begin
                        r_kl <= r_kl + KW'(1);
                        r_jl <= r_kl;
                    end else begin
                        r_jl <= r_jl - KW'(1);
                    end
                end
                default: begin
                    r_kl <= r_kl;
                    r_jl <= r_jl;
                end
            endcase
        end
    end

    // output register: load a result beat, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_ctl.out_ld) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_ld) begin
            r_oval <= r_rda;
            r_oend <= emit_last;
            r_oovf <= r_drop;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.sorted_value = r_oval;
    assign o_out.end_of_run   = r_oend;
    assign o_out.overflowed   = r_oovf;

    `BSAL_ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_ELEMENTS), "element count above capacity")
    `BSAL_ASSERT_IMP(a_drop_full, i_clk, i_rst_n, r_drop, full, "drop flagged while store not full")
    `BSAL_ASSERT_IMP(a_load_free, i_clk, i_rst_n, i_ctl.out_ld, out_free, "result loaded over a pending beat")

endmodule

`default_nettype wire

// File: sv/bitonic_sorter_any_length_unit.sv
// Loading: one element per cycle, accepted whenever the sequencer is in its load step.
// After the final beat, with P = MAX_ELEMENTS rounded up to a power of two, S = log2(P),
// n stored elements: the store is padded up to P entries, then S*(S+1)/2 network stages
// run (one memory pair read and two writes per compare-exchange), then n results are emitted.
// Synchronous active-low reset clears count, drop flag, sequencer and sets ascending order.
`default_nettype none

module bitonic_sorter_any_length_unit #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    bsal_in_if.sink    i_in,
    bsal_out_if.source o_out
);
    import bsal_pkg::*;

    t_ctl    ctl;
    t_status status;

    // microcode sequencer
    bsal_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctl    (ctl)
    );

    // store, compare-exchange datapath and output register
    bsal_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (ctl),
        .o_status    (status),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: test/bitonic_sorter_any_length_unit_tb.sv
`timescale 1ns / 100ps

module bitonic_sorter_any_length_unit_tb;

    import bsal_pkg::*;

    localparam int MAX_ELEM    = 64;
    localparam int RESET_CYC   = 12;
    localparam int SETTLE_CYC  = 40;
    localparam int HOLD_CYC    = 300;

    typedef struct packed {
        t_val value;
        logic last_beat;
    } t_elem_beat;

    typedef struct packed {
        t_val value;
        logic end_of_run;
        logic overflowed;
    } t_sorted_beat;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    bsal_in_if  in_if ();
    bsal_out_if out_if ();

    bitonic_sorter_any_length_unit #(
        .MAX_ELEMENTS (MAX_ELEM)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // stimulus and expectations
    t_elem_beat   elem_queue[$];
    t_sorted_beat sorted_expect[$];
    int unsigned  beats_queued;
    int unsigned  beats_taken;
    int unsigned  err_count;

    // predictor state
    t_val         batch_store[MAX_ELEM];
    int unsigned  batch_fill;
    logic         batch_dropped;
    logic         order_up;

    // idling controls
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    logic         pressure_on;
    int unsigned  hold_count;
    logic         in_took;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Store one element (or flag a drop when full); on the closing beat, sort the batch and queue its results
    task automatic absorb_element(input t_val v, input logic last_beat);
        t_val         ord[MAX_ELEM];
        t_val         key;
        int unsigned  n;
        int           j;
        t_sorted_beat exp_beat;
        if (batch_fill < MAX_ELEM) begin
            batch_store[batch_fill] = v;
            batch_fill++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (last_beat) begin
            n = batch_fill;
            for (int i = 0; i < n; i++) ord[i] = batch_store[i];
            for (int i = 1; i < n; i++) begin
                key = ord[i];
                j = i;
                while (j > 0 && (order_up ? (ord[j-1] > key) : (ord[j-1] < key))) begin
                    ord[j] = ord[j-1];
                    j--;
                end
                ord[j] = key;
            end
            for (int i = 0; i < n; i++) begin
                exp_beat.value      = ord[i];
                exp_beat.end_of_run = (i == n - 1);
                exp_beat.overflowed = batch_dropped;
                sorted_expect = {sorted_expect, exp_beat};
            end
            batch_fill    = 0;
            batch_dropped = 1'b0;
        end
    endtask

    // Sample both channels and the config port at the rising edge
    always @(posedge i_clk) begin : monitor
        t_sorted_beat exp_beat;
        in_took = in_if.valid && in_if.ready;
        if (!i_rst_n) begin
            batch_fill    = 0;
            batch_dropped = 1'b0;
            order_up      = 1'b1;
        end else begin
            if (i_cfg_we) order_up = i_cfg_wdata;
            if (in_took) begin
                beats_taken++;
                absorb_element(in_if.value, in_if.final_item);
            end
            if (out_if.valid && out_if.ready) begin
                if (sorted_expect.size() == 0) begin
                    err_count++;
                    $display("%0t: expected no result, got value %0d end %b ovf %b",
                             $time, out_if.sorted_value, out_if.end_of_run,
                             out_if.overflowed);
                end else begin
                    exp_beat = sorted_expect.pop_front();
                    if (out_if.sorted_value !== exp_beat.value) begin
                        err_count++;
                        $display("%0t: sorted_value expected %0d got %0d",
                                 $time, exp_beat.value, out_if.sorted_value);
                    end
                    if (out_if.end_of_run !== exp_beat.end_of_run) begin
                        err_count++;
                        $display("%0t: end_of_run expected %b got %b",
                                 $time, exp_beat.end_of_run, out_if.end_of_run);
                    end
                    if (out_if.overflowed !== exp_beat.overflowed) begin
                        err_count++;
                        $display("%0t: overflowed expected %b got %b",
                                 $time, exp_beat.overflowed, out_if.overflowed);
                    end
                end
            end
        end
    end

    // Drive input beats from the pending queue at the falling edge
    always @(negedge i_clk) begin : drive_in
        t_elem_beat nxt;
        if (i_rst_n && (!in_if.valid || in_took)) begin
            if (elem_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = elem_queue.pop_front();
                in_if.valid      <= 1'b1;
                in_if.value      <= nxt.value;
                in_if.final_item <= nxt.last_beat;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Drive output ready; under pressure, hold off once results start to appear
    always @(negedge i_clk) begin : drive_out_ready
        if (pressure_on && hold_count < HOLD_CYC && (hold_count != 0 || out_if.valid)) begin
            hold_count   <= hold_count + 1;
            out_if.ready <= 1'b0;
        end else begin
            if (!pressure_on) hold_count <= 0;
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_beat(input t_val v, input logic last_beat);
        t_elem_beat b;
        b.value     = v;
        b.last_beat = last_beat;
        elem_queue = {elem_queue, b};
        beats_queued++;
    endtask

    // Mix full-range, narrow, extreme and repeated values
    function automatic t_val pick_value(input t_val prev);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            5, 6: return t_val'(int'($urandom_range(0, 16)) - 8);
            7: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return t_val'(0);
                    default: return t_val'(-1);
                endcase
            end
            8, 9: return prev;
            default: return t_val'($urandom);
        endcase
    endfunction

    task automatic add_batch(input int unsigned n);
        t_val v;
        v = t_val'($urandom);
        for (int unsigned k = 0; k < n; k++) begin
            v = pick_value(v);
            push_beat(v, k == n - 1);
        end
    endtask

    // Wait until every beat is taken and every result seen, then let the block go idle
    task automatic settle();
        while (beats_taken != beats_queued || sorted_expect.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_order(input logic up);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = up;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin : stimulus
        t_val corner_vals[7];
        corner_vals = '{VAL_MAX, VAL_MIN, t_val'(0), t_val'(-1), t_val'(1), VAL_MAX, VAL_MIN};
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 1'b0;
        in_if.valid      = 1'b0;
        in_if.value      = '0;
        in_if.final_item = 1'b0;
        out_if.ready     = 1'b0;
        in_took          = 1'b0;
        beats_queued     = 0;
        beats_taken      = 0;
        err_count        = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        pressure_on      = 1'b0;
        hold_count       = 0;
        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: single element, extremes ascending
        push_beat(VAL_MIN, 1'b1);
        foreach (corner_vals[i]) push_beat(corner_vals[i], i == 6);
        settle();

        // directed: descending, extremes, equal values, alternating bit patterns
        write_order(1'b0);
        foreach (corner_vals[i]) push_beat(corner_vals[i], i == 6);
        push_beat(t_val'(5), 1'b0);
        push_beat(t_val'(5), 1'b0);
        push_beat(t_val'(-5), 1'b0);
        push_beat(t_val'(32'hAAAA_AAAA), 1'b0);
        push_beat(t_val'(32'h5555_5555), 1'b0);
        push_beat(t_val'(5), 1'b1);
        push_beat(VAL_MAX, 1'b1);
        settle();

        // sender mostly idle, ascending
        write_order(1'b1);
        send_idle_pct = 83;
        add_batch($urandom_range(1, 5));
        add_batch($urandom_range(1, 5));
        settle();

        // receiver mostly stalled, descending; overflow batch drops its tail
        write_order(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        add_batch(MAX_ELEM + 2);
        add_batch($urandom_range(1, 4));
        settle();

        // light idling on both sides, ascending
        write_order(1'b1);
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        repeat (2) add_batch($urandom_range(1, 6));
        settle();

        // long receiver hold-off while the next batch waits at the input
        write_order(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_on    = 1'b1;
        add_batch($urandom_range(4, 8));
        add_batch($urandom_range(4, 8));
        settle();
        pressure_on = 1'b0;

        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Bound the run well beyond the slowest correct case
    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
